@@ src/wts_pkg.sv @@
package wts_pkg;

    // Item kinds.
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Register map, low address byte.
    localparam logic [7:0] ADDR_VOLUME     = 8'h80;
    localparam logic [7:0] ADDR_WPITCH_LO  = 8'h82;
    localparam logic [7:0] ADDR_WPITCH_HI  = 8'h83;
    localparam logic [7:0] ADDR_MGAIN      = 8'h84;
    localparam logic [7:0] ADDR_MCOUNT     = 8'h85;
    localparam logic [7:0] ADDR_MPITCH_LO  = 8'h86;
    localparam logic [7:0] ADDR_MPITCH_HI  = 8'h87;
    localparam logic [7:0] ADDR_MTABLE     = 8'h88;
    localparam logic [7:0] ADDR_CTRL       = 8'h89;
    localparam logic [7:0] ADDR_VOLUME_RD  = 8'h90;
    localparam logic [7:0] ADDR_MGAIN_RD   = 8'h92;
    localparam logic [1:0] WAVE_WINDOW     = 2'b01;

    localparam int SAMPLE_W = 6;
    localparam int MODVAL_W = 3;
    localparam int PITCH_W  = 12;
    localparam int PHASE_W  = 16;
    localparam int COUNT_W  = 7;
    localparam int LEVEL_W  = 12;
    localparam int SCALE_W  = 9;

    // Modulation table value that clears the counter.
    localparam logic [MODVAL_W-1:0] MOD_CLEAR = 3'd4;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX = 12'd3969;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] addr;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         read_data;
        logic [LEVEL_W-1:0] level;
    } out_item_t;

    // Master attenuation in Q8: 1, 2/3, 1/3, 1/4.
    function automatic logic [SCALE_W-1:0] att_scale(input logic [1:0] att);
        logic [SCALE_W-1:0] s;
        begin
            unique case (att)
                2'd0:    s = 9'd256;
                2'd1:    s = 9'd171;
                2'd2:    s = 9'd85;
                default: s = 9'd64;
            endcase
            return s;
        end
    endfunction

endpackage

@@ src/wts_stream_if.sv @@
interface wts_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ src/wavetable_synth_with_modulation_core.sv @@
// Wavetable oscillator with frequency modulation, driven by a byte-wide register bus.
// The in_ch channel carries one request per item: a bus write, a bus read or one
// audio clock tick (func, addr, data). The out_ch channel returns exactly one
// result per request: the read byte (zero unless a read) and the output level.
// Requests are handled one at a time. A request is taken in the cycle after the
// previous one has finished. Each passes the execute step, then the level read,
// multiply and scale steps; a modulation table write adds a second table write, a
// wave table read captures its data in place of the level read, a tick that moves the
// voice adds the pitch product, clamp and phase advance, and a tick that steps the table
// adds the counter update. Steps follow the registered reads of both tables, the multiplies and phase adders.
// A finished result sits in an output register, so the next request is taken
// while the receiver stalls; that request then waits at its last step until
// the output register is free. Reset clears all control state, sets the volume
// to 32 and marks every entry of both tables as zero through per-entry valid
// bits, so there is no clearing pass and the block is ready right after reset.
module wavetable_synth_with_modulation_core #(
    parameter int WAVE_ENTRIES = 64,
    parameter int MOD_ENTRIES  = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    wts_stream_if.sink   in_ch,
    wts_stream_if.source out_ch
);

    localparam int WAVE_AW = $clog2(WAVE_ENTRIES);
    localparam int MOD_AW  = $clog2(MOD_ENTRIES);
    // The modulation index counts half steps, so it carries one bit more.
    localparam int MIDX_W  = MOD_AW + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MODW2,
        S_MODUPD,
        S_PROD,
        S_PITCH,
        S_ADV,
        S_RDCAP,
        S_LVLRD,
        S_LVLMUL,
        S_LVLSCALE
    } state_t;

    state_t state_reg, state_next;

    // Latched request.
    logic [1:0] func_reg;
    logic [7:0] addr_reg;
    logic [7:0] data_reg;

    // Sound registers.
    logic                              wave_write_on_reg, wave_write_on_next;
    logic [wts_pkg::PITCH_W-1:0]       wave_pitch_reg, wave_pitch_next;
    logic [wts_pkg::PHASE_W-1:0]       wave_phase_reg, wave_phase_next;
    logic [WAVE_AW-1:0]                wave_index_reg, wave_index_next;
    logic [wts_pkg::SAMPLE_W-1:0]      volume_reg, volume_next;
    logic [1:0]                        att_reg, att_next;
    logic                              sound_on_reg, sound_on_next;
    logic [wts_pkg::PITCH_W-1:0]       mod_pitch_reg, mod_pitch_next;
    logic [wts_pkg::PHASE_W-1:0]       mod_phase_reg, mod_phase_next;
    logic [MIDX_W-1:0]                 mod_index_reg, mod_index_next;
    logic signed [wts_pkg::COUNT_W-1:0] mod_count_reg, mod_count_next;
    logic                              mod_on_reg, mod_on_next;
    logic [wts_pkg::SAMPLE_W-1:0]      mod_gain_reg, mod_gain_next;

    // Working registers of one request.
    logic [7:0]                        rdata_reg, rdata_next;
    logic signed [12:0]                prod_reg, prod_next;
    logic [wts_pkg::PITCH_W-1:0]       pitch_reg, pitch_next;
    logic [11:0]                       vprod_reg, vprod_next;

    // Output register.
    logic                              out_valid_reg, out_valid_next;
    logic [7:0]                        out_rdata_reg, out_rdata_next;
    logic [wts_pkg::LEVEL_W-1:0]       out_level_reg, out_level_next;

    // Table memories and their valid bits; an entry never written reads as zero.
    logic                              wave_we;
    logic [WAVE_AW-1:0]                wave_waddr, wave_raddr;
    logic [wts_pkg::SAMPLE_W-1:0]      wave_rdata, wave_sample;
    logic [WAVE_ENTRIES-1:0]           wave_valid_reg;
    logic                              wave_rvalid_reg;
    logic                              mod_we;
    logic [MOD_AW-1:0]                 mod_waddr, mod_raddr;
    logic [wts_pkg::MODVAL_W-1:0]      mod_rdata, mod_sample;
    logic [MOD_ENTRIES-1:0]            mod_valid_reg;
    logic                              mod_rvalid_reg;

    // Combinational helpers.
    logic                              in_fire;
    logic                              is_wave;
    logic                              out_free;
    logic [wts_pkg::PHASE_W:0]         mod_sum;
    logic [wts_pkg::PHASE_W:0]         wave_sum;
    logic signed [7:0]                 count_sum;
    logic signed [13:0]                prod_full;
    logic signed [12:0]                prod_biased;
    logic signed [6:0]                 pitch_quot;
    logic signed [13:0]                pitch_sum;
    logic [20:0]                       scaled;

    wts_ram #(
        .WIDTH (wts_pkg::SAMPLE_W),
        .DEPTH (WAVE_ENTRIES)
    ) u_wave_ram (
        .clk   (clk),
        .we    (wave_we),
        .waddr (wave_waddr),
        .wdata (data_reg[wts_pkg::SAMPLE_W-1:0]),
        .raddr (wave_raddr),
        .rdata (wave_rdata)
    );

    wts_ram #(
        .WIDTH (wts_pkg::MODVAL_W),
        .DEPTH (MOD_ENTRIES)
    ) u_mod_ram (
        .clk   (clk),
        .we    (mod_we),
        .waddr (mod_waddr),
        .wdata (data_reg[wts_pkg::MODVAL_W-1:0]),
        .raddr (mod_raddr),
        .rdata (mod_rdata)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign is_wave     = (addr_reg[7:6] == wts_pkg::WAVE_WINDOW);
    assign out_free    = !out_valid_reg || out_ch.ready;

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.payload.read_data = out_rdata_reg;
    assign out_ch.payload.level     = out_level_reg;

    assign wave_sample = wave_rvalid_reg ? wave_rdata : '0;
    assign mod_sample  = mod_rvalid_reg ? mod_rdata : '0;

    // The wave table is read at the request address in the execute step, where
    // only a read uses the data, and at the current wave position otherwise.
    // The modulation table is only used on a tick. A write in the execute step
    // only meets a read whose data is dropped, so no forwarding is needed.
    assign wave_waddr = addr_reg[WAVE_AW-1:0];
    assign wave_raddr = (state_reg == S_EXEC) ? addr_reg[WAVE_AW-1:0] : wave_index_reg;
    assign mod_raddr  = mod_index_reg[MIDX_W-1:1];
    assign mod_waddr  = (state_reg == S_MODW2)
                        ? MOD_AW'(mod_index_reg[MOD_AW-1:0] + 1'b1)
                        : mod_index_reg[MOD_AW-1:0];

    // Arithmetic.
    assign mod_sum     = {1'b0, mod_phase_reg} + {{(wts_pkg::PHASE_W + 1 - wts_pkg::PITCH_W){1'b0}},
                         mod_pitch_reg};
    assign wave_sum    = {1'b0, wave_phase_reg} + {{(wts_pkg::PHASE_W + 1 - wts_pkg::PITCH_W){1'b0}},
                         pitch_reg};
    assign count_sum   = {mod_count_reg[wts_pkg::COUNT_W-1], mod_count_reg}
                         + $signed({5'b0, mod_sample});
    assign prod_full   = mod_count_reg * $signed({1'b0, mod_gain_reg});
    // Division by 64 rounds toward zero: bias negative products before the shift.
    assign prod_biased = prod_reg[12] ? (prod_reg + 13'sd63) : prod_reg;
    assign pitch_quot  = prod_biased[12:6];
    assign pitch_sum   = $signed({2'b00, wave_pitch_reg}) + 14'(pitch_quot);
    assign scaled      = vprod_reg * wts_pkg::att_scale(att_reg);

    always_comb
    begin
        state_next         = state_reg;
        wave_write_on_next = wave_write_on_reg;
        wave_pitch_next    = wave_pitch_reg;
        wave_phase_next    = wave_phase_reg;
        wave_index_next    = wave_index_reg;
        volume_next        = volume_reg;
        att_next           = att_reg;
        sound_on_next      = sound_on_reg;
        mod_pitch_next     = mod_pitch_reg;
        mod_phase_next     = mod_phase_reg;
        mod_index_next     = mod_index_reg;
        mod_count_next     = mod_count_reg;
        mod_on_next        = mod_on_reg;
        mod_gain_next      = mod_gain_reg;
        rdata_next         = rdata_reg;
        prod_next          = prod_reg;
        pitch_next         = pitch_reg;
        vprod_next         = vprod_reg;
        out_valid_next     = out_valid_reg && !out_ch.ready;
        out_rdata_next     = out_rdata_reg;
        out_level_next     = out_level_reg;
        wave_we            = 1'b0;
        mod_we             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                rdata_next = '0;
                state_next = S_LVLRD;
                priority if (func_reg == wts_pkg::FUNC_WRITE)
                begin
                    if (is_wave)
                    begin
                        wave_we = wave_write_on_reg;
                    end
                    else
                    begin
                        unique case (addr_reg)
                            wts_pkg::ADDR_VOLUME:
                            begin
                                if (data_reg[7])
                                begin
                                    volume_next = data_reg[5:0];
                                end
                            end
                            wts_pkg::ADDR_WPITCH_LO:
                            begin
                                wave_pitch_next = {wave_pitch_reg[11:8], data_reg};
                            end
                            wts_pkg::ADDR_WPITCH_HI:
                            begin
                                wave_pitch_next = {data_reg[3:0], wave_pitch_reg[7:0]};
                                sound_on_next   = !data_reg[7];
                                if (data_reg[7])
                                begin
                                    wave_phase_next = '0;
                                end
                            end
                            wts_pkg::ADDR_MGAIN:
                            begin
                                if (data_reg[7])
                                begin
                                    mod_gain_next = data_reg[5:0];
                                end
                            end
                            wts_pkg::ADDR_MCOUNT:
                            begin
                                mod_count_next = $signed(data_reg[6:0]);
                            end
                            wts_pkg::ADDR_MPITCH_LO:
                            begin
                                mod_pitch_next = {mod_pitch_reg[11:8], data_reg};
                            end
                            wts_pkg::ADDR_MPITCH_HI:
                            begin
                                mod_pitch_next = {data_reg[3:0], mod_pitch_reg[7:0]};
                                mod_on_next    = !data_reg[7];
                                if (data_reg[7])
                                begin
                                    mod_phase_next = '0;
                                end
                            end
                            wts_pkg::ADDR_MTABLE:
                            begin
                                // Each table write fills two neighboring entries.
                                if (!mod_on_reg)
                                begin
                                    mod_we     = 1'b1;
                                    state_next = S_MODW2;
                                end
                            end
                            wts_pkg::ADDR_CTRL:
                            begin
                                att_next           = data_reg[1:0];
                                wave_write_on_next = data_reg[7];
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                else if (func_reg == wts_pkg::FUNC_READ)
                begin
                    if (is_wave)
                    begin
                        state_next = S_RDCAP;
                    end
                    else if (addr_reg == wts_pkg::ADDR_VOLUME_RD)
                    begin
                        rdata_next = {2'b01, volume_reg};
                    end
                    else if (addr_reg == wts_pkg::ADDR_MGAIN_RD)
                    begin
                        rdata_next = {2'b01, mod_gain_reg};
                    end
                end
                else if (func_reg == wts_pkg::FUNC_TICK)
                begin
                    if (sound_on_reg && (wave_pitch_reg != '0))
                    begin
                        state_next = S_PROD;
                        if (mod_on_reg && (mod_pitch_reg != '0))
                        begin
                            mod_phase_next = mod_sum[wts_pkg::PHASE_W-1:0];
                            if (mod_sum[wts_pkg::PHASE_W])
                            begin
                                // The table read at the old index is in flight now.
                                mod_index_next = MIDX_W'(mod_index_reg + 1'b1);
                                state_next     = S_MODUPD;
                            end
                        end
                    end
                end
                else
                begin
                end
            end

            S_MODW2:
            begin
                mod_we         = 1'b1;
                mod_index_next = MIDX_W'(mod_index_reg + 2'd2);
                state_next     = S_LVLRD;
            end

            S_MODUPD:
            begin
                if (mod_sample == wts_pkg::MOD_CLEAR)
                begin
                    mod_count_next = '0;
                end
                else if (!count_sum[7] && count_sum[6])
                begin
                    mod_count_next = 7'sd63;
                end
                else
                begin
                    mod_count_next = count_sum[6:0];
                end
                state_next = S_PROD;
            end

            S_PROD:
            begin
                prod_next  = (mod_on_reg && (mod_gain_reg != '0)) ? prod_full[12:0] : '0;
                state_next = S_PITCH;
            end

            S_PITCH:
            begin
                if (pitch_sum[13])
                begin
                    pitch_next = '0;
                end
                else if (pitch_sum[12])
                begin
                    pitch_next = '1;
                end
                else
                begin
                    pitch_next = pitch_sum[11:0];
                end
                state_next = S_ADV;
            end

            S_ADV:
            begin
                wave_phase_next = wave_sum[wts_pkg::PHASE_W-1:0];
                if (wave_sum[wts_pkg::PHASE_W])
                begin
                    wave_index_next = WAVE_AW'(wave_index_reg + 1'b1);
                end
                state_next = S_LVLRD;
            end

            S_RDCAP:
            begin
                // The level read at the wave position is issued in this cycle too.
                rdata_next = {2'b01, wave_sample};
                state_next = S_LVLMUL;
            end

            S_LVLRD:
            begin
                state_next = S_LVLMUL;
            end

            S_LVLMUL:
            begin
                vprod_next = wave_sample * volume_reg;
                state_next = S_LVLSCALE;
            end

            S_LVLSCALE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rdata_next = rdata_reg;
                    out_level_next = (sound_on_reg && !wave_write_on_reg)
                                     ? scaled[19:8] : '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            wave_write_on_reg <= 1'b0;
            wave_pitch_reg    <= '0;
            wave_phase_reg    <= '0;
            wave_index_reg    <= '0;
            volume_reg        <= 6'd32;
            att_reg           <= '0;
            sound_on_reg      <= 1'b0;
            mod_pitch_reg     <= '0;
            mod_phase_reg     <= '0;
            mod_index_reg     <= '0;
            mod_count_reg     <= '0;
            mod_on_reg        <= 1'b0;
            mod_gain_reg      <= '0;
            out_valid_reg     <= 1'b0;
            out_rdata_reg     <= '0;
            out_level_reg     <= '0;
            wave_valid_reg    <= '0;
            mod_valid_reg     <= '0;
            wave_rvalid_reg   <= 1'b0;
            mod_rvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            wave_write_on_reg <= wave_write_on_next;
            wave_pitch_reg    <= wave_pitch_next;
            wave_phase_reg    <= wave_phase_next;
            wave_index_reg    <= wave_index_next;
            volume_reg        <= volume_next;
            att_reg           <= att_next;
            sound_on_reg      <= sound_on_next;
            mod_pitch_reg     <= mod_pitch_next;
            mod_phase_reg     <= mod_phase_next;
            mod_index_reg     <= mod_index_next;
            mod_count_reg     <= mod_count_next;
            mod_on_reg        <= mod_on_next;
            mod_gain_reg      <= mod_gain_next;
            out_valid_reg     <= out_valid_next;
            out_rdata_reg     <= out_rdata_next;
            out_level_reg     <= out_level_next;
            wave_rvalid_reg   <= wave_valid_reg[wave_raddr];
            mod_rvalid_reg    <= mod_valid_reg[mod_raddr];
            if (wave_we)
            begin
                wave_valid_reg[wave_waddr] <= 1'b1;
            end
            if (mod_we)
            begin
                mod_valid_reg[mod_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= in_ch.payload.func;
            addr_reg <= in_ch.payload.addr;
            data_reg <= in_ch.payload.data;
        end
        rdata_reg     <= rdata_next;
        prod_reg      <= prod_next;
        pitch_reg     <= pitch_next;
        vprod_reg     <= vprod_next;
    end

`ifndef SYNTHESIS
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.payload.level <= wts_pkg::LEVEL_MAX))
        else $error("output level out of range");

    a_read_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.payload.read_data != '0)) |-> out_ch.payload.read_data[6])
        else $error("nonzero read data without its tag bit");

    a_modw2_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MODW2) |-> (($past(state_reg) == S_EXEC) && !mod_on_reg))
        else $error("second table write without a table write request");

    a_level_read_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LVLMUL) |->
            (($past(state_reg) == S_LVLRD) || ($past(state_reg) == S_RDCAP)))
        else $error("level multiply without a wave position read");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_EXEC))
        else $error("accepted request not executed");
`endif

endmodule

@@ src/wts_ram.sv @@
module wts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sim/wavetable_synth_with_modulation_core_tb.sv @@
module wavetable_synth_with_modulation_core_tb;

    import wts_pkg::*;

    localparam int WAVE_ENTRIES = 64;
    localparam int MOD_ENTRIES  = 32;

    // Random part: stop building once this many requests are queued.
    localparam int REQUEST_TARGET = 800;
    // A run ends in failure when no request is taken and no result returned
    // for this many cycles. The longest legal quiet stretch is the receiver
    // hold-off below plus the slowest request, so this leaves a wide margin.
    localparam int STALL_LIMIT = 3000;
    // The receiver holds off once, after this many results, for this long.
    localparam int HOLD_AFTER  = 200;
    localparam int HOLD_CYCLES = 300;
    // Cycles allowed after the last expected result for a stray one to show.
    localparam int DRAIN_CYCLES = 40;

    // Bus reads of mapped registers come back with bit 6 set.
    localparam logic [7:0] READ_TAG = 8'h40;
    // Output scale for each master attenuation step, in Q8.
    localparam int ATT_Q8 [4] = '{256, 171, 85, 64};

    logic clk = 1'b0;
    logic rst_n;

    wts_stream_if #(.payload_t(in_item_t))  in_ch ();
    wts_stream_if #(.payload_t(out_item_t)) out_ch ();

    wavetable_synth_with_modulation_core #(
        .WAVE_ENTRIES(WAVE_ENTRIES),
        .MOD_ENTRIES (MOD_ENTRIES)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Synthesizer state as the testbench sees it. It moves only when a
    // request is taken on in_ch, so it always describes the block after the
    // last accepted request.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0]       wave_tab [WAVE_ENTRIES];
    logic [MODVAL_W-1:0]       mod_tab  [MOD_ENTRIES];
    logic                      wave_wr_en;
    logic                      snd_on;
    logic                      mod_en;
    logic                      env_off;
    logic [PITCH_W-1:0]        w_pitch;
    logic [PITCH_W-1:0]        m_pitch;
    logic [PHASE_W:0]          w_phase;
    logic [PHASE_W:0]          m_phase;
    logic [5:0]                w_index;
    logic [5:0]                m_index;
    logic [5:0]                vol;
    logic [5:0]                m_gain;
    logic [1:0]                atten;
    logic signed [COUNT_W-1:0] m_count;

    // What the run went through, for the closing summary.
    int n_writes, n_reads, n_ticks, n_unused;
    int mod_steps, wave_steps, count_clears, count_clamps;
    int pitch_floor_hits, pitch_ceiling_hits, loud_results;

    int fail_count;

    // Requests waiting to be offered, and results still owed by the block.
    in_item_t  bus_requests[$];
    out_item_t predicted_outputs[$];

    // Applies one request to the state above and returns the read byte and
    // the output level that the block must report for it.
    task automatic synth_step(input in_item_t req, output out_item_t res);
        logic [MODVAL_W-1:0] step_val;
        logic [4:0]          pair_slot;
        int                  sum;
        int                  bent;
        int                  prod;
        int                  lvl;
        begin
            res.read_data = '0;
            case (req.func)
                FUNC_WRITE:
                begin
                    n_writes++;
                    if (req.addr[7:6] == WAVE_WINDOW)
                    begin
                        // The wave RAM only takes data while wave writing is on.
                        if (wave_wr_en)
                            wave_tab[req.addr[5:0]] = req.data[SAMPLE_W-1:0];
                    end
                    else
                    begin
                        case (req.addr)
                            ADDR_VOLUME:
                            begin
                                env_off = req.data[7];
                                if (req.data[7])
                                    vol = req.data[5:0];
                            end
                            ADDR_WPITCH_LO:
                                w_pitch[7:0] = req.data;
                            ADDR_WPITCH_HI:
                            begin
                                w_pitch[11:8] = req.data[3:0];
                                snd_on = !req.data[7];
                                if (req.data[7])
                                    w_phase = '0;
                            end
                            ADDR_MGAIN:
                            begin
                                if (req.data[7])
                                    m_gain = req.data[5:0];
                            end
                            ADDR_MCOUNT:
                                // Seven bits taken as a two's complement value.
                                m_count = req.data[COUNT_W-1:0];
                            ADDR_MPITCH_LO:
                                m_pitch[7:0] = req.data;
                            ADDR_MPITCH_HI:
                            begin
                                m_pitch[11:8] = req.data[3:0];
                                mod_en = !req.data[7];
                                if (req.data[7])
                                    m_phase = '0;
                            end
                            ADDR_MTABLE:
                            begin
                                // Each write fills a pair of slots and moves the
                                // index by two; ignored while modulation runs.
                                if (!mod_en)
                                begin
                                    pair_slot = m_index[4:0] + 5'd1;
                                    mod_tab[m_index[4:0]] = req.data[MODVAL_W-1:0];
                                    mod_tab[pair_slot]    = req.data[MODVAL_W-1:0];
                                    m_index = m_index + 6'd2;
                                end
                            end
                            ADDR_CTRL:
                            begin
                                atten      = req.data[1:0];
                                wave_wr_en = req.data[7];
                            end
                            default:
                                ;
                        endcase
                    end
                end
                FUNC_READ:
                begin
                    n_reads++;
                    if (req.addr[7:6] == WAVE_WINDOW)
                        res.read_data = READ_TAG | {2'b00, wave_tab[req.addr[5:0]]};
                    else if (req.addr == ADDR_VOLUME_RD)
                        res.read_data = READ_TAG | {2'b00, vol};
                    else if (req.addr == ADDR_MGAIN_RD)
                        res.read_data = READ_TAG | {2'b00, m_gain};
                end
                FUNC_TICK:
                begin
                    n_ticks++;
                    // A muted or pitchless voice does not move at all.
                    if (snd_on && w_pitch != '0)
                    begin
                        if (mod_en && m_pitch != '0)
                        begin
                            m_phase = m_phase + m_pitch;
                            if (m_phase[PHASE_W])
                            begin
                                m_phase[PHASE_W] = 1'b0;
                                // The table is read at half the index, as the
                                // index runs twice as fast as the table.
                                step_val = mod_tab[m_index[5:1]];
                                m_index  = m_index + 6'd1;
                                mod_steps++;
                                if (step_val == MOD_CLEAR)
                                begin
                                    m_count = '0;
                                    count_clears++;
                                end
                                else
                                begin
                                    sum = int'(m_count) + int'(step_val);
                                    if (sum > 63)
                                    begin
                                        sum = 63;
                                        count_clamps++;
                                    end
                                    if (sum < -64)
                                        sum = -64;
                                    m_count = sum[COUNT_W-1:0];
                                end
                            end
                        end
                        // The counter bends the pitch by count * gain / 64,
                        // rounded toward zero and held within twelve bits.
                        bent = int'(w_pitch);
                        if (m_gain != '0 && mod_en)
                        begin
                            prod = int'(m_count) * int'(m_gain);
                            bent = bent + prod / 64;
                            if (bent < 0)
                            begin
                                bent = 0;
                                pitch_floor_hits++;
                            end
                            if (bent > 4095)
                            begin
                                bent = 4095;
                                pitch_ceiling_hits++;
                            end
                        end
                        w_phase = w_phase + bent[PITCH_W-1:0];
                        if (w_phase[PHASE_W])
                        begin
                            w_phase[PHASE_W] = 1'b0;
                            w_index = w_index + 6'd1;
                            wave_steps++;
                        end
                    end
                end
                default:
                    n_unused++;
            endcase

            // The level follows the current sample, silent while muted or
            // while the wave RAM is open for writing.
            if (!snd_on || wave_wr_en)
                res.level = '0;
            else
            begin
                lvl = int'(wave_tab[w_index]) * int'(vol) * ATT_Q8[atten];
                res.level = LEVEL_W'(lvl >> 8);
            end
        end
    endtask

    task automatic push_req(input logic [1:0] f, input logic [7:0] a, input logic [7:0] d);
        in_item_t r;
        begin
            r.func = f;
            r.addr = a;
            r.data = d;
            bus_requests.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: offers queued requests in bursts of random length with random
    // gaps between them. A request stays on the bus until it is taken.
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid   <= 1'b0;
            in_ch.payload <= '0;
            burst_left = $urandom_range(1, 24);
            gap_left   = 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (bus_requests.size() > 0)
            begin
                in_ch.payload <= bus_requests.pop_front();
                in_ch.valid   <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    // A quarter of the bursts run straight into the next one.
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: switches between stretches of full readiness, coin-flip
    // readiness and one-in-four readiness. Once in the run it holds off for
    // a long stretch so that the output register fills and the block stops
    // taking requests while the sender keeps offering.
    // ------------------------------------------------------------------
    int rx_mode;
    int rx_left;
    int rx_taken;
    int hold_left;
    bit hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_mode   = 0;
            rx_left   = 0;
            rx_taken  = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                rx_taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!hold_done && rx_taken >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = $urandom_range(0, 2);
                    rx_left = $urandom_range(20, 200);
                end
                else
                    rx_left--;
                case (rx_mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    default: out_ch.ready <= (rx_left % 4 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks a returned result against the oldest prediction
    // first, then predicts the result of a request taken at the same edge.
    // Both happen in this one block so their order is fixed.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t fresh;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (out_ch.payload.level != '0)
                    loud_results++;
                if (predicted_outputs.size() == 0)
                begin
                    $error("result with no request outstanding: read_data %0h, level %0d",
                           out_ch.payload.read_data, out_ch.payload.level);
                    fail_count++;
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    if (out_ch.payload.read_data !== want.read_data)
                    begin
                        $error("read_data mismatch: expected %0h, actual %0h",
                               want.read_data, out_ch.payload.read_data);
                        fail_count++;
                    end
                    if (out_ch.payload.level !== want.level)
                    begin
                        $error("level mismatch: expected %0d, actual %0d",
                               want.level, out_ch.payload.level);
                        fail_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                synth_step(in_ch.payload, fresh);
                predicted_outputs.push_back(fresh);
            end
        end
    end

    // Watchdog on quiet cycles: nothing taken and nothing returned.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("handshake timeout after %0d quiet cycles, %0d results owed",
                         quiet_cycles, predicted_outputs.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        int         n;
        int         pick;
        int         mode;
        logic [11:0] wp;
        logic [11:0] mp;
        logic [7:0]  rd_addr;

        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        rst_n         = 1'b0;

        // State right after reset: everything cleared, volume at 32.
        foreach (wave_tab[i])
            wave_tab[i] = '0;
        foreach (mod_tab[i])
            mod_tab[i] = '0;
        wave_wr_en = 1'b0;
        snd_on     = 1'b0;
        mod_en     = 1'b0;
        env_off    = 1'b0;
        w_pitch    = '0;
        m_pitch    = '0;
        w_phase    = '0;
        m_phase    = '0;
        w_index    = '0;
        m_index    = '0;
        vol        = 6'd32;
        m_gain     = '0;
        atten      = '0;
        m_count    = '0;
        fail_count = 0;

        // Directed opening: reset values, unmapped reads, the unused item
        // kind, a write to the wave RAM while it is closed, then one voice
        // set up at full pitch and gain with the counter at its lowest, and
        // a table write that must be ignored while modulation runs.
        push_req(FUNC_READ, ADDR_VOLUME_RD, 8'h00);
        push_req(FUNC_READ, ADDR_MGAIN_RD, 8'h00);
        push_req(FUNC_READ, 8'h7F, 8'h00);
        push_req(FUNC_READ, 8'h00, 8'hFF);
        push_req(FUNC_READ, 8'h91, 8'h00);
        push_req(2'd3, 8'hFF, 8'hFF);
        push_req(FUNC_WRITE, 8'h40, 8'h3F);
        push_req(FUNC_WRITE, ADDR_CTRL, 8'h83);
        push_req(FUNC_WRITE, 8'h40, 8'hFF);
        push_req(FUNC_WRITE, 8'h7F, 8'hC1);
        push_req(FUNC_READ, 8'h40, 8'h00);
        push_req(FUNC_READ, 8'h7F, 8'h00);
        push_req(FUNC_WRITE, ADDR_CTRL, 8'h01);
        push_req(FUNC_WRITE, ADDR_VOLUME, 8'hBF);
        push_req(FUNC_WRITE, ADDR_VOLUME, 8'h12);
        push_req(FUNC_WRITE, ADDR_WPITCH_LO, 8'hFF);
        push_req(FUNC_WRITE, ADDR_WPITCH_HI, 8'h0F);
        push_req(FUNC_WRITE, ADDR_MGAIN, 8'hBF);
        push_req(FUNC_WRITE, ADDR_MTABLE, 8'h07);
        push_req(FUNC_WRITE, ADDR_MCOUNT, 8'h40);
        push_req(FUNC_WRITE, ADDR_MPITCH_LO, 8'hFF);
        push_req(FUNC_WRITE, ADDR_MPITCH_HI, 8'h0F);
        push_req(FUNC_TICK, 8'h00, 8'h00);
        push_req(FUNC_WRITE, ADDR_MTABLE, 8'h04);
        push_req(FUNC_WRITE, ADDR_WPITCH_HI, 8'h80);
        push_req(FUNC_TICK, 8'h00, 8'h00);
        push_req(FUNC_WRITE, ADDR_MPITCH_HI, 8'h80);

        // Random part, built as complete voice setups so that ticks reach the
        // modulation and wave stepping, each followed by a stretch of play
        // mixed with reads, live register changes and random noise.
        while (bus_requests.size() < REQUEST_TARGET)
        begin
            // Open the wave RAM and load some of it.
            push_req(FUNC_WRITE, ADDR_CTRL, {1'b1, 5'($urandom), 2'($urandom)});
            n = $urandom_range(4, 64);
            repeat (n)
                push_req(FUNC_WRITE, {WAVE_WINDOW, 6'($urandom)}, 8'($urandom));
            repeat ($urandom_range(0, 3))
                push_req(FUNC_READ, {WAVE_WINDOW, 6'($urandom)}, 8'($urandom));
            push_req(FUNC_WRITE, ADDR_CTRL, {1'b0, 5'($urandom), 2'($urandom)});

            // Volume, mostly with the envelope bit set so that it loads.
            push_req(FUNC_WRITE, ADDR_VOLUME,
                     {($urandom_range(0, 4) != 0), 7'($urandom)});

            // Wave pitch: very low (to reach the floor), near the top (to
            // reach the ceiling) or anything.
            mode = $urandom_range(0, 2);
            case (mode)
                0:       wp = 12'($urandom_range(1, 80));
                1:       wp = 12'($urandom_range(12'hF80, 12'hFFF));
                default: wp = 12'($urandom);
            endcase
            push_req(FUNC_WRITE, ADDR_WPITCH_LO, wp[7:0]);
            push_req(FUNC_WRITE, ADDR_WPITCH_HI,
                     {($urandom_range(0, 7) == 0), 3'($urandom), wp[11:8]});

            // Stop modulation so the table can be loaded.
            mode = $urandom_range(0, 3);
            case (mode)
                0, 1:    mp = 12'($urandom_range(12'hC00, 12'hFFF));
                2:       mp = 12'($urandom);
                default: mp = '0;
            endcase
            push_req(FUNC_WRITE, ADDR_MPITCH_HI, {1'b1, 3'($urandom), mp[11:8]});
            push_req(FUNC_WRITE, ADDR_MPITCH_LO, mp[7:0]);
            repeat ($urandom_range(0, 12))
                push_req(FUNC_WRITE, ADDR_MTABLE, 8'($urandom));

            // Gain (sometimes the largest), counter, then modulation on most of the time.
            if ($urandom_range(0, 3) == 0)
                push_req(FUNC_WRITE, ADDR_MGAIN, {1'b1, 1'($urandom), 6'h3F});
            else
                push_req(FUNC_WRITE, ADDR_MGAIN,
                         {($urandom_range(0, 5) != 0), 7'($urandom)});
            push_req(FUNC_WRITE, ADDR_MCOUNT, 8'($urandom));
            push_req(FUNC_WRITE, ADDR_MPITCH_HI,
                     {($urandom_range(0, 5) == 0), 3'($urandom), mp[11:8]});
            if ($urandom_range(0, 2) == 0)
                push_req(FUNC_READ, ADDR_MGAIN_RD, 8'($urandom));

            // Play.
            n = $urandom_range(20, 60);
            repeat (n)
            begin
                pick = $urandom_range(0, 11);
                if (pick < 8)
                    push_req(FUNC_TICK, 8'($urandom), 8'($urandom));
                else if (pick == 8)
                begin
                    case ($urandom_range(0, 3))
                        0:       rd_addr = ADDR_VOLUME_RD;
                        1:       rd_addr = ADDR_MGAIN_RD;
                        2:       rd_addr = {WAVE_WINDOW, 6'($urandom)};
                        default: rd_addr = 8'($urandom);
                    endcase
                    push_req(FUNC_READ, rd_addr, 8'($urandom));
                end
                else if (pick == 9)
                begin
                    case ($urandom_range(0, 4))
                        0:       rd_addr = ADDR_MGAIN;
                        1:       rd_addr = ADDR_MCOUNT;
                        2:       rd_addr = ADDR_VOLUME;
                        3:       rd_addr = ADDR_WPITCH_LO;
                        default: rd_addr = ADDR_MPITCH_LO;
                    endcase
                    push_req(FUNC_WRITE, rd_addr, 8'($urandom));
                end
                else
                    push_req(2'($urandom), 8'($urandom), 8'($urandom));
            end
        end

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Sampled between edges so the checks see settled values.
        while (bus_requests.size() > 0 || in_ch.valid)
            @(negedge clk);
        while (predicted_outputs.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d writes, %0d reads, %0d ticks and %0d unused requests.",
                 n_writes, n_reads, n_ticks, n_unused);
        $display("Saw %0d modulation steps (%0d clears, %0d counter clamps), %0d wave steps,",
                 mod_steps, count_clears, count_clamps, wave_steps);
        $display("%0d/%0d pitch floor/ceiling hits and %0d audible results.",
                 pitch_floor_hits, pitch_ceiling_hits, loud_results);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
